### hdl/mt3_pkg.sv
// Package for the 3x3 mirror tile reader: sizes, codes and channel word types.
// Used by the channel interfaces, the fold unit, the store and the top level.
package mt3_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers are 7 bits; index fields are 8 bits.
  localparam int DIM_W    = 7;
  localparam int IDX_W    = 8;
  // Working width of the fold arithmetic: holds 3 * dimension and MAX_ROWS/MAX_COLS.
  localparam int FOLD_W   = 12;
  localparam int DATA_W   = 64;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic [DATA_W-1:0] data_word;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              out_of_range;
  } out_word_t;

endpackage

### hdl/mt3_req_if.sv
// Request channel: valid/ready handshake carrying one input word.
// Depends on mt3_pkg for the word type.
interface mt3_req_if;
  import mt3_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/mt3_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on mt3_pkg for the word type.
interface mt3_rsp_if;
  import mt3_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/mt3_fold.sv
// Fold of one virtual index onto the source by comparison with n, 2n and 3n.
// Depends on mt3_pkg for widths.
module mt3_fold (
  input  logic [mt3_pkg::IDX_W-1:0]  v,
  input  logic [mt3_pkg::DIM_W-1:0]  n,
  output logic                       in_range,
  output logic [mt3_pkg::FOLD_W-1:0] idx
);
  import mt3_pkg::*;

  logic [FOLD_W-1:0] vx;
  logic [FOLD_W-1:0] n1;
  logic [FOLD_W-1:0] n2;
  logic [FOLD_W-1:0] n3;

  assign vx = FOLD_W'(v);
  assign n1 = FOLD_W'(n);
  assign n2 = n1 << 1;
  assign n3 = n2 + n1;

  assign in_range = (vx < n3);

  // Left or upper tile is mirrored, centre is direct, right or lower is mirrored.
  always_comb begin
    if (vx < n1) begin
      idx = n1 - FOLD_W'(1) - vx;
    end else if (vx < n2) begin
      idx = vx - n1;
    end else begin
      idx = n3 - FOLD_W'(1) - vx;
    end
  end
endmodule

### hdl/mt3_store.sv
// Source matrix store: one write port and one read port with registered data.
// Depends on mt3_pkg for depth and widths; contents are undefined until written.
module mt3_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [mt3_pkg::ADDR_W-1:0] wr_addr,
  input  logic [mt3_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [mt3_pkg::ADDR_W-1:0] rd_addr,
  output logic [mt3_pkg::DATA_W-1:0] rd_data
);
  import mt3_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

### hdl/mirror_tile_3x3_reader.sv
// 3x3 mirror tile reader. While ready is high, one word may follow every cycle.
// A read issues its store read at the accepting edge; its result is valid when the output
// register loads from the store's read data. Ready is low while a read waits on the store
// or on a full output register, so no word is taken until that read has been passed on.
// Reset clears the dimension registers and the control state; the store is not
// cleared and its contents are undefined until written.
module mirror_tile_3x3_reader (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [mt3_pkg::DIM_W-1:0] cfg_data,
  mt3_req_if.sink                   req,
  mt3_rsp_if.source                 rsp
);
  import mt3_pkg::*;

  logic [DIM_W-1:0]  row_count;
  logic [DIM_W-1:0]  col_count;
  logic [DIM_W-1:0]  cfg_rows_sat;
  logic [DIM_W-1:0]  cfg_cols_sat;

  logic              pend;
  logic              pend_oor;
  logic              pend_done;

  logic              accept;
  logic              rd_accept;
  logic              wr_accept;
  logic              wr_inside;

  logic              row_in_range;
  logic              col_in_range;
  logic [FOLD_W-1:0] row_src;
  logic [FOLD_W-1:0] col_src;

  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;

  // Dimensions saturate at the store size when written.
  assign cfg_rows_sat = (FOLD_W'(cfg_data) > FOLD_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : cfg_data;
  assign cfg_cols_sat = (FOLD_W'(cfg_data) > FOLD_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROW_COUNT: row_count <= cfg_rows_sat;
        CFG_COL_COUNT: col_count <= cfg_cols_sat;
        default: ;
      endcase
    end
  end

  assign req.ready = !pend;
  assign accept    = req.valid && req.ready;
  assign rd_accept = accept && (req.data.func == FUNC_READ);
  assign wr_accept = accept && (req.data.func == FUNC_WRITE);

  mt3_fold u_row_fold (
    .v        (req.data.row_index),
    .n        (row_count),
    .in_range (row_in_range),
    .idx      (row_src)
  );

  mt3_fold u_col_fold (
    .v        (req.data.col_index),
    .n        (col_count),
    .in_range (col_in_range),
    .idx      (col_src)
  );

  // Writes outside the source matrix are dropped.
  assign wr_inside = (FOLD_W'(req.data.row_index) < FOLD_W'(row_count)) &&
                     (FOLD_W'(req.data.col_index) < FOLD_W'(col_count));

  assign wr_addr = ADDR_W'(32'(req.data.row_index) * 32'(MAX_COLS) +
                           32'(req.data.col_index));
  assign rd_addr = ADDR_W'(32'(row_src) * 32'(MAX_COLS) + 32'(col_src));

  // A write lands at the clock edge of its acceptance, so a read accepted in the
  // next cycle already sees it and no forwarding is needed.
  mt3_store u_store (
    .clk     (clk),
    .wr_en   (wr_accept && wr_inside),
    .wr_addr (wr_addr),
    .wr_data (req.data.data_word),
    .rd_en   (rd_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign pend_done = pend && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rd_accept) begin
        pend     <= 1'b1;
        pend_oor <= !(row_in_range && col_in_range);
      end else if (pend_done) begin
        pend <= 1'b0;
      end
      // The output register empties on its own handshake, unless a pending read loads it in the same cycle.
      if (pend_done) begin
        rsp.valid             <= 1'b1;
        rsp.data.read_value   <= pend_oor ? '0 : rd_data;
        rsp.data.out_of_range <= pend_oor;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // A result word only appears after a read has been waiting on the store.
  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(pend))
    else $error("result word without a pending read");

  // An out-of-range result carries a zero value.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.out_of_range) |-> (rsp.data.read_value == '0))
    else $error("out-of-range result with non-zero value");

  // A write into an idle block never produces a result word.
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (wr_accept && !rsp.valid) |=> !rsp.valid)
    else $error("write produced a result word");

  // No word is accepted in the cycle after a read is accepted.
  a_read_interlock: assert property (@(posedge clk) disable iff (rst)
    rd_accept |=> !accept)
    else $error("word accepted while a read waits on the store");

endmodule
